FILE: hw/rtl/sawas_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sawas_pkg
// Types, codes and checksum helpers shared by the stop-and-wait ARQ sender.
// ----------------------------------------------------------------------------
package sawas_pkg;

  localparam int unsigned MAX_CHUNK       = 4096;
  localparam int unsigned SEQ_MODULUS_DEF = 256;
  localparam int unsigned QUEUE_DEPTH     = 2;
  localparam int unsigned CFG_IDX_W       = 2;

  localparam logic [2:0] OP_CONNECT    = 3'd0;
  localparam logic [2:0] OP_SEND       = 3'd1;
  localparam logic [2:0] OP_FINISH     = 3'd2;
  localparam logic [2:0] OP_DISCONNECT = 3'd3;
  localparam logic [2:0] OP_RX_HEADER  = 3'd4;
  localparam logic [2:0] OP_TICK       = 3'd5;

  localparam logic [15:0] FL_DATA     = 16'h0000;
  localparam logic [15:0] FL_SYN      = 16'h0001;
  localparam logic [15:0] FL_ACK      = 16'h0002;
  localparam logic [15:0] FL_SYN_ACK  = 16'h0003;
  localparam logic [15:0] FL_FIN      = 16'h0004;
  localparam logic [15:0] FL_OVER     = 16'h0007;
  localparam logic [15:0] FL_OVER_ACK = 16'h000A;

  localparam logic [CFG_IDX_W-1:0] CFG_DATA_TIMEOUT    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CONNECT_TIMEOUT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CLOSE_TIMEOUT   = 2'd2;

  localparam logic [31:0] DATA_TIMEOUT_RST    = 32'd500;
  localparam logic [31:0] CONNECT_TIMEOUT_RST = 32'd75000;
  localparam logic [31:0] CLOSE_TIMEOUT_RST   = 32'd37500;

  typedef enum logic [3:0] {
    PH_IDLE          = 4'd0,
    PH_WAIT_SYNACK   = 4'd1,
    PH_CONNECTED     = 4'd2,
    PH_WAIT_DATA_ACK = 4'd3,
    PH_WAIT_OVER_ACK = 4'd4,
    PH_WAIT_FIN_ACK  = 4'd5,
    PH_WAIT_FIN      = 4'd6,
    PH_CLOSED        = 4'd7,
    PH_FAILED        = 4'd8
  } sawas_phase_e;

  typedef enum logic [2:0] {
    EV_NONE     = 3'd0,
    EV_NEW      = 3'd1,
    EV_RETX     = 3'd2,
    EV_ACCEPT   = 3'd3,
    EV_REJECT   = 3'd4,
    EV_CONNFAIL = 3'd5,
    EV_IGNORED  = 3'd6
  } sawas_event_e;

  typedef enum logic [2:0] {
    KIND_CONNECT,
    KIND_SEND,
    KIND_FINISH,
    KIND_DISCONNECT,
    KIND_RX,
    KIND_TICK,
    KIND_NONE
  } sawas_kind_e;

  typedef struct packed {
    logic [2:0]  operation;
    logic [12:0] chunk_len;
    logic [15:0] payload_sum;
    logic [15:0] rx_len;
    logic [15:0] rx_checksum;
    logic [15:0] rx_flag;
    logic [15:0] rx_ack;
    logic [15:0] rx_seq;
  } sawas_in_t;

  typedef struct packed {
    logic        send_now;
    logic [15:0] tx_len;
    logic [15:0] tx_checksum;
    logic [15:0] tx_flag;
    logic [15:0] tx_ack;
    logic [15:0] tx_seq;
    logic [3:0]  phase_now;
    logic [2:0]  event_code;
  } sawas_out_t;

  // classified command passed from front to back
  typedef struct packed {
    sawas_kind_e kind;
    logic        chunk_ok;
    logic [12:0] chunk_len;
    logic [15:0] part_sum;
    logic        rx_ok;
    logic        rx_synack_ok;
    logic        rx_overack_ok;
    logic        rx_ack_ok;
    logic        rx_fin_ok;
    logic [15:0] rx_ack;
  } sawas_cmd_t;

  typedef struct packed {
    logic [15:0] len;
    logic [15:0] checksum;
    logic [15:0] flag;
    logic [15:0] seq;
  } sawas_hdr_t;

  function automatic logic [15:0] ones_add(logic [15:0] a, logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[15:0] + {15'd0, s[16]};
  endfunction

  function automatic sawas_hdr_t build_hdr(logic [15:0] len, logic [15:0] flag,
                                           logic [15:0] seq, logic [15:0] part);
    sawas_hdr_t h;
    h.len      = len;
    h.flag     = flag;
    h.seq      = seq;
    h.checksum = ~ones_add(ones_add(part, flag), seq);
    return h;
  endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/sawas_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sawas_front
// Decodes input beats and checks received headers before they are queued.
// ----------------------------------------------------------------------------
module sawas_front
  import sawas_pkg::*;
(
  input  sawas_in_t  in_i,
  output sawas_cmd_t cmd_o
);

  logic [15:0] rx_sum;
  logic [15:0] len16;

  assign len16  = {3'd0, in_i.chunk_len};
  assign rx_sum = ones_add(ones_add(ones_add(ones_add(in_i.rx_len, in_i.rx_checksum),
                                             in_i.rx_flag), in_i.rx_ack), in_i.rx_seq);

  always_comb begin
    unique case (in_i.operation)
      OP_CONNECT:    cmd_o.kind = KIND_CONNECT;
      OP_SEND:       cmd_o.kind = KIND_SEND;
      OP_FINISH:     cmd_o.kind = KIND_FINISH;
      OP_DISCONNECT: cmd_o.kind = KIND_DISCONNECT;
      OP_RX_HEADER:  cmd_o.kind = KIND_RX;
      OP_TICK:       cmd_o.kind = KIND_TICK;
      default:       cmd_o.kind = KIND_NONE;
    endcase
    cmd_o.chunk_ok      = {4'd0, in_i.chunk_len} <= 17'(MAX_CHUNK);
    cmd_o.chunk_len     = in_i.chunk_len;
    cmd_o.part_sum      = ones_add(len16, in_i.payload_sum);
    cmd_o.rx_ok         = rx_sum == 16'hFFFF;
    cmd_o.rx_synack_ok  = cmd_o.rx_ok && (in_i.rx_flag == FL_SYN_ACK);
    cmd_o.rx_overack_ok = cmd_o.rx_ok && (in_i.rx_flag == FL_OVER_ACK);
    cmd_o.rx_ack_ok     = cmd_o.rx_ok && (in_i.rx_flag == FL_ACK);
    cmd_o.rx_fin_ok     = cmd_o.rx_ok && (in_i.rx_flag == FL_FIN);
    cmd_o.rx_ack        = in_i.rx_ack;
  end

endmodule
`default_nettype wire

FILE: hw/rtl/sawas_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sawas_fifo
// Short command queue between the front and back parts.
// ----------------------------------------------------------------------------
module sawas_fifo
  import sawas_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  sawas_cmd_t data_i,
  output logic       full_o,
  input  logic       pop_i,
  output logic       valid_o,
  output sawas_cmd_t data_o
);

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  sawas_cmd_t       mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] count_q;
  logic             do_push, do_pop;

  assign full_o  = count_q == CNT_W'(QUEUE_DEPTH);
  assign valid_o = count_q != '0;
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  function automatic logic [PTR_W-1:0] ptr_inc(logic [PTR_W-1:0] p);
    return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= ptr_inc(wr_ptr_q);
      end
      if (do_pop) begin
        rd_ptr_q <= ptr_inc(rd_ptr_q);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - CNT_W'(1);
      end
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/sawas_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sawas_back
// Protocol state machine, timers, header build and result register.
// ----------------------------------------------------------------------------
module sawas_back
  import sawas_pkg::*;
#(
  parameter int unsigned SEQ_MODULUS = SEQ_MODULUS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cmd_valid_i,
  input  sawas_cmd_t           cmd_i,
  output logic                 cmd_pop_o,
  input  logic                 cfg_valid_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [31:0]          cfg_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output sawas_out_t           out_data_o
);

  localparam int unsigned SEQ_W = (SEQ_MODULUS > 1) ? $clog2(SEQ_MODULUS) : 1;

  sawas_phase_e     phase_q, phase_d;
  logic [SEQ_W-1:0] seq_q, seq_d, seq_inc;
  logic [31:0]      wait_q, wait_d;
  sawas_hdr_t       last_q, last_d;
  logic [31:0]      data_to_q, conn_to_q, close_to_q;
  logic             out_valid_q;
  sawas_out_t       out_q, out_d;
  logic             fire;
  logic             send;
  sawas_event_e     ev;
  logic [32:0]      wait_inc;
  logic [31:0]      limit;
  logic             has_timer;

  assign fire      = cmd_valid_i && (!out_valid_q || out_ready_i);
  assign cmd_pop_o = fire;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign seq_inc  = (seq_q == SEQ_W'(SEQ_MODULUS - 1)) ? '0 : seq_q + SEQ_W'(1);
  assign wait_inc = {1'b0, wait_q} + 33'd1;

  always_comb begin
    phase_d   = phase_q;
    seq_d     = seq_q;
    wait_d    = wait_q;
    last_d    = last_q;
    send      = 1'b0;
    ev        = EV_IGNORED;
    limit     = data_to_q;
    has_timer = 1'b0;
    unique case (cmd_i.kind)
      KIND_CONNECT: begin
        if (phase_q == PH_IDLE || phase_q == PH_CLOSED || phase_q == PH_FAILED) begin
          seq_d   = '0;
          last_d  = build_hdr(16'd0, FL_SYN, 16'd0, 16'd0);
          phase_d = PH_WAIT_SYNACK;
          wait_d  = '0;
          send    = 1'b1;
          ev      = EV_NEW;
        end
      end
      KIND_SEND: begin
        if (phase_q == PH_CONNECTED && cmd_i.chunk_ok) begin
          last_d  = build_hdr({3'd0, cmd_i.chunk_len}, FL_DATA, 16'(seq_q), cmd_i.part_sum);
          phase_d = PH_WAIT_DATA_ACK;
          wait_d  = '0;
          send    = 1'b1;
          ev      = EV_NEW;
        end
      end
      KIND_FINISH: begin
        if (phase_q == PH_CONNECTED) begin
          last_d  = build_hdr(16'd0, FL_OVER, 16'd0, 16'd0);
          phase_d = PH_WAIT_OVER_ACK;
          wait_d  = '0;
          send    = 1'b1;
          ev      = EV_NEW;
        end
      end
      KIND_DISCONNECT: begin
        if (phase_q == PH_CONNECTED) begin
          last_d  = build_hdr(16'd0, FL_FIN, 16'd0, 16'd0);
          phase_d = PH_WAIT_FIN_ACK;
          wait_d  = '0;
          send    = 1'b1;
          ev      = EV_NEW;
        end
      end
      KIND_RX: begin
        unique case (phase_q)
          PH_WAIT_SYNACK: begin
            if (cmd_i.rx_synack_ok) begin
              last_d  = build_hdr(16'd0, FL_ACK, 16'd1, 16'd0);
              phase_d = PH_CONNECTED;
              send    = 1'b1;
              ev      = EV_ACCEPT;
            end else begin
              phase_d = PH_FAILED;
              ev      = EV_CONNFAIL;
            end
          end
          PH_WAIT_DATA_ACK: begin
            if (cmd_i.rx_ok && cmd_i.rx_ack == 16'(seq_inc)) begin
              seq_d   = seq_inc;
              phase_d = PH_CONNECTED;
              ev      = EV_ACCEPT;
            end else begin
              wait_d = '0;
              send   = 1'b1;
              ev     = EV_REJECT;
            end
          end
          PH_WAIT_OVER_ACK: begin
            if (cmd_i.rx_overack_ok) begin
              phase_d = PH_CONNECTED;
              ev      = EV_ACCEPT;
            end else begin
              ev = EV_REJECT;
            end
          end
          PH_WAIT_FIN_ACK: begin
            if (cmd_i.rx_ack_ok) begin
              phase_d = PH_WAIT_FIN;
              ev      = EV_ACCEPT;
            end else begin
              ev = EV_REJECT;
            end
          end
          PH_WAIT_FIN: begin
            if (cmd_i.rx_fin_ok) begin
              last_d  = build_hdr(16'd0, FL_ACK, 16'd1, 16'd0);
              phase_d = PH_CLOSED;
              send    = 1'b1;
              ev      = EV_ACCEPT;
            end else begin
              ev = EV_REJECT;
            end
          end
          default: ;
        endcase
      end
      KIND_TICK: begin
        ev = EV_NONE;
        unique case (phase_q)
          PH_WAIT_SYNACK: begin
            limit     = conn_to_q;
            has_timer = 1'b1;
          end
          PH_WAIT_DATA_ACK, PH_WAIT_OVER_ACK: begin
            limit     = data_to_q;
            has_timer = 1'b1;
          end
          PH_WAIT_FIN_ACK: begin
            limit     = close_to_q;
            has_timer = 1'b1;
          end
          default: ;
        endcase
        if (has_timer) begin
          if (wait_inc >= {1'b0, limit}) begin
            wait_d = '0;
            send   = 1'b1;
            ev     = EV_RETX;
          end else begin
            wait_d = wait_inc[31:0];
          end
        end
      end
      default: ;
    endcase

    out_d.send_now    = send;
    out_d.tx_len      = send ? last_d.len : 16'd0;
    out_d.tx_checksum = send ? last_d.checksum : 16'd0;
    out_d.tx_flag     = send ? last_d.flag : 16'd0;
    out_d.tx_ack      = 16'd0;
    out_d.tx_seq      = send ? last_d.seq : 16'd0;
    out_d.phase_now   = phase_d;
    out_d.event_code  = ev;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      seq_q   <= '0;
      wait_q  <= '0;
      last_q  <= '0;
    end else if (fire) begin
      phase_q <= phase_d;
      seq_q   <= seq_d;
      wait_q  <= wait_d;
      last_q  <= last_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      data_to_q  <= DATA_TIMEOUT_RST;
      conn_to_q  <= CONNECT_TIMEOUT_RST;
      close_to_q <= CLOSE_TIMEOUT_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_DATA_TIMEOUT:    data_to_q  <= cfg_data_i;
        CFG_CONNECT_TIMEOUT: conn_to_q  <= cfg_data_i;
        CFG_CLOSE_TIMEOUT:   close_to_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_q <= out_d;
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/stop_and_wait_arq_sender_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stop_and_wait_arq_sender_core
// Sender side of a stop-and-wait ARQ link with five-word headers.
// ----------------------------------------------------------------------------
// One beat is accepted per cycle while the queue is not full; each accepted
// beat yields exactly one result beat, offered by the result register. The
// front decodes the command and checks the received header checksum, a
// two-entry queue decouples it from the back, and the back updates the
// protocol state, timer and header per beat, so the sustained rate is one
// beat per cycle while the output is not stalled. Configuration writes are
// always taken and must be issued only while the block is idle.
module stop_and_wait_arq_sender_core
  import sawas_pkg::*;
#(
  parameter int unsigned SEQ_MODULUS = SEQ_MODULUS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  sawas_in_t            in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output sawas_out_t           out_data_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [31:0]          cfg_data_i
);

  sawas_cmd_t front_cmd, queue_cmd;
  logic       queue_full, queue_valid, queue_pop;

  assign in_ready_o  = !queue_full;
  assign cfg_ready_o = 1'b1;

  sawas_front u_front (
    .in_i  (in_data_i),
    .cmd_o (front_cmd)
  );

  sawas_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (in_valid_i),
    .data_i  (front_cmd),
    .full_o  (queue_full),
    .pop_i   (queue_pop),
    .valid_o (queue_valid),
    .data_o  (queue_cmd)
  );

  sawas_back #(
    .SEQ_MODULUS (SEQ_MODULUS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (queue_valid),
    .cmd_i       (queue_cmd),
    .cmd_pop_o   (queue_pop),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
`default_nettype wire

FILE: hw/rtl/sawas_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sawas_checker
// Port-level checks of the result channel of the ARQ sender.
// ----------------------------------------------------------------------------
module sawas_checker
  import sawas_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input sawas_out_t out_data_i
);

  // stalled beat holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i))
    else $error("stalled result beat changed");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_data_i.send_now |->
      out_data_i.tx_len == 16'd0 && out_data_i.tx_checksum == 16'd0 &&
      out_data_i.tx_flag == 16'd0 && out_data_i.tx_seq == 16'd0)
    else $error("header fields set without send");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_data_i.event_code == EV_RETX ||
                    out_data_i.event_code == EV_NEW) |-> out_data_i.send_now)
    else $error("new or resent beat without header");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_data_i.event_code == EV_NEW |->
      out_data_i.phase_now == PH_WAIT_SYNACK || out_data_i.phase_now == PH_WAIT_DATA_ACK ||
      out_data_i.phase_now == PH_WAIT_OVER_ACK || out_data_i.phase_now == PH_WAIT_FIN_ACK)
    else $error("new header without a waiting phase");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_data_i.event_code == EV_CONNFAIL |->
      out_data_i.phase_now == PH_FAILED && !out_data_i.send_now)
    else $error("connect failure with wrong phase");

endmodule

bind stop_and_wait_arq_sender_core sawas_checker u_sawas_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_i  (out_data_o)
);
`default_nettype wire
